// ===== rtl/core/tcb_pkg.sv =====
package tcb_pkg;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 32;
	localparam int CELL_BITS = 16;
	localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(STORE_CELLS);

	localparam logic [2:0] REQ_SET = 3'd0;
	localparam logic [2:0] REQ_FILL = 3'd1;
	localparam logic [2:0] REQ_COPY = 3'd2;
	localparam logic [2:0] REQ_VSCROLL = 3'd3;
	localparam logic [2:0] REQ_HSCROLL = 3'd4;
	localparam logic [2:0] REQ_READ = 3'd5;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	// one rectangle operation as handed to the back end
	typedef struct packed {
		logic              is_copy;
		logic              is_read;
		logic              last;
		logic              result;
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic signed [11:0] w;
		logic signed [11:0] h;
		logic signed [11:0] dx;
		logic signed [11:0] dy;
		logic [CELL_BITS-1:0] value;
	} op_t;

endpackage

// ===== rtl/core/tcb_front.sv =====
module tcb_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            req_type,
	input  logic [15:0]           cell_value,
	input  logic                  whole_screen,
	input  logic signed [8:0]     rect_x,
	input  logic signed [8:0]     rect_y,
	input  logic [7:0]            rect_w,
	input  logic [7:0]            rect_h,
	input  logic signed [8:0]     dest_x,
	input  logic signed [8:0]     dest_y,
	input  logic signed [8:0]     scroll_amount,
	input  logic [8:0]            eff_cols,
	input  logic [8:0]            eff_rows,
	output logic                  op_valid,
	output tcb_pkg::op_t          op,
	input  logic                  op_ready,
	input  logic                  back_idle
);
	import tcb_pkg::*;

	op_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic active_q;

	op_t o0, o1;
	logic [1:0] n;
	logic signed [11:0] x, y, w, h, a, s;
	logic [CELL_BITS-1:0] v;
	logic on_scr;

	always_comb begin
		x = 12'(rect_x);
		y = 12'(rect_y);
		w = 12'(rect_w);
		h = 12'(rect_h);
		on_scr = rect_x >= 0 && x < 12'(eff_cols) && rect_y >= 0 && y < 12'(eff_rows);
		if (whole_screen) begin
			x = '0;
			y = '0;
			w = 12'(eff_cols);
			h = 12'(eff_rows);
		end
		v = CELL_BITS'(cell_value);
		s = 12'(scroll_amount);
		a = s < 0 ? -s : s;
		o0 = '0;
		o1 = '0;
		o0.value = v;
		o1.value = v;
		n = 2'd1;
		unique case (req_type)
			REQ_SET, REQ_READ: begin
				o0.x = x;
				o0.y = y;
				o0.w = on_scr ? 12'sd1 : 12'sd0;
				o0.h = 12'sd1;
				o0.is_read = req_type == REQ_READ;
				o0.last = 1'b1;
				o0.result = 1'b1;
			end
			REQ_FILL: begin
				o0.x = x;
				o0.y = y;
				o0.w = w;
				o0.h = h;
				o0.last = 1'b1;
				o0.result = 1'b1;
			end
			REQ_COPY: begin
				o0.is_copy = 1'b1;
				o0.x = x;
				o0.y = y;
				o0.w = w;
				o0.h = h;
				o0.dx = 12'(dest_x);
				o0.dy = 12'(dest_y);
				o0.last = 1'b1;
				o0.result = 1'b1;
			end
			REQ_VSCROLL, REQ_HSCROLL: begin
				if (s == 0) begin
					o0.w = '0;
					o0.last = 1'b1;
					o0.result = 1'b1;
				end else begin
					n = 2'd2;
					o0.is_copy = 1'b1;
					o1.last = 1'b1;
					o1.result = 1'b1;
					o0.x = x;
					o0.y = y;
					o0.dx = x;
					o0.dy = y;
					o0.w = w;
					o0.h = h;
					o1.x = x;
					o1.y = y;
					o1.w = w;
					o1.h = h;
					if (req_type == REQ_VSCROLL) begin
						o0.h = h - a;
						o1.h = a;
						if (s > 0) o0.dy = y + a;
						else begin
							o0.y = y + a;
							o1.y = y + h - a;
						end
					end else begin
						o0.w = w - a;
						o1.w = a;
						if (s > 0) o0.dx = x + a;
						else begin
							o0.x = x + a;
							o1.x = x + w - a;
						end
					end
				end
			end
			default: begin
				o0.w = '0;
				o0.last = 1'b1;
				o0.result = 1'b1;
			end
		endcase
	end

	assign busy = active_q;
	assign op_valid = cnt_q != 2'd0 && !rd_q;
	assign op = q_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			active_q <= 1'b0;
		end else begin
			if (start && !active_q) begin
				active_q <= 1'b1;
				cnt_q <= n;
				rd_q <= 1'b0;
			end else if (op_valid && op_ready) begin
				cnt_q <= cnt_q - 2'd1;
				rd_q <= 1'b1;
			end else if (rd_q && back_idle) begin
				rd_q <= 1'b0;
				if (cnt_q == 2'd0) active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !active_q) begin
			q_q[0] <= o0;
			q_q[1] <= o1;
		end else if (op_valid && op_ready) begin
			q_q[0] <= q_q[1];
		end
	end

endmodule

// ===== rtl/core/tcb_back.sv =====
module tcb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [8:0]            eff_cols,
	input  logic [8:0]            eff_rows,
	input  logic                  op_valid,
	input  tcb_pkg::op_t          op,
	output logic                  op_ready,
	output logic                  idle,
	output logic                  done,
	output logic [15:0]           read_cell,
	output logic                  nothing_done
);
	import tcb_pkg::*;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CLIP1 = 3'd2;
	localparam logic [2:0] ST_CLIP2 = 3'd3;
	localparam logic [2:0] ST_ADDR  = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_WR    = 3'd6;
	localparam logic [2:0] ST_RES   = 3'd7;

	logic [2:0] state_q;
	op_t op_q;
	logic acc_q;
	logic signed [11:0] sx0_q, sy0_q, dx0_q, dy0_q, nc_q, nr_q;
	logic [8:0] r_q, c_q;
	logic [ADDR_W-1:0] clr_q, sa_q, da_q;
	logic [CELL_BITS-1:0] mem [STORE_CELLS];
	logic [CELL_BITS-1:0] rdat_q;
	logic rows_fwd_q, cols_fwd_q;

	logic signed [11:0] cx0, cy0, cx1, cy1, ec, er;
	logic signed [11:0] ri, ci, sxa, sya, dxa, dya;
	logic [ADDR_W-1:0] sa_n, da_n;
	logic [19:0] sprod, dprod;

	always_comb begin
		ec = 12'(eff_cols);
		er = 12'(eff_rows);
		if (state_q == ST_CLIP1) begin
			cx0 = op_q.x < 0 ? 12'sd0 : op_q.x;
			cy0 = op_q.y < 0 ? 12'sd0 : op_q.y;
			cx1 = op_q.x + op_q.w - 12'sd1;
			cy1 = op_q.y + op_q.h - 12'sd1;
		end else begin
			cx0 = op_q.dx < 0 ? 12'sd0 : op_q.dx;
			cy0 = op_q.dy < 0 ? 12'sd0 : op_q.dy;
			cx1 = op_q.dx + nc_q - 12'sd1;
			cy1 = op_q.dy + nr_q - 12'sd1;
		end
		if (cx1 >= ec) cx1 = ec - 12'sd1;
		if (cy1 >= er) cy1 = er - 12'sd1;
		ri = rows_fwd_q ? 12'(r_q) : nr_q - 12'sd1 - 12'(r_q);
		ci = cols_fwd_q ? 12'(c_q) : nc_q - 12'sd1 - 12'(c_q);
		sxa = sx0_q + ci;
		sya = sy0_q + ri;
		dxa = dx0_q + ci;
		dya = dy0_q + ri;
		sprod = 20'(sxa) + 20'(sya) * 20'(eff_cols);
		dprod = 20'(dxa) + 20'(dya) * 20'(eff_cols);
		sa_n = sprod < 20'(STORE_CELLS) ? ADDR_W'(sprod) : '0;
		da_n = dprod < 20'(STORE_CELLS) ? ADDR_W'(dprod) : '0;
	end

	assign op_ready = state_q == ST_IDLE;
	assign idle = state_q == ST_IDLE && !op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			done <= 1'b0;
			acc_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_CELLS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (op_valid) begin
						state_q <= ST_CLIP1;
						if (op.result && op.last && !op.is_copy && op.w == 0 && op.h == 1)
							acc_q <= acc_q;
					end
				end
				ST_CLIP1: begin
					if (cx0 > cx1 || cy0 > cy1) begin
						state_q <= ST_RES;
					end else begin
						state_q <= op_q.is_copy ? ST_CLIP2 : ST_ADDR;
						if (!op_q.is_copy) begin
							acc_q <= 1'b1;
						end
					end
				end
				ST_CLIP2: begin
					if (cx0 > cx1 || cy0 > cy1) state_q <= ST_RES;
					else begin
						state_q <= ST_ADDR;
						acc_q <= 1'b1;
					end
				end
				ST_ADDR: state_q <= op_q.is_copy || op_q.is_read ? ST_RD : ST_WR;
				ST_RD: state_q <= op_q.is_read ? ST_RES : ST_WR;
				ST_WR: begin
					if (12'(c_q) + 12'sd1 < nc_q) state_q <= ST_ADDR;
					else if (12'(r_q) + 12'sd1 < nr_q) state_q <= ST_ADDR;
					else state_q <= ST_RES;
				end
				ST_RES: begin
					state_q <= ST_IDLE;
					if (op_q.last) begin
						done <= 1'b1;
						acc_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CLR: mem[clr_q] <= '0;
			ST_IDLE: begin
				op_q <= op;
				r_q <= '0;
				c_q <= '0;
				rdat_q <= '0;
			end
			ST_CLIP1: begin
				sx0_q <= cx0;
				sy0_q <= cy0;
				nc_q <= cx1 - cx0 + 12'sd1;
				nr_q <= cy1 - cy0 + 12'sd1;
				dx0_q <= cx0;
				dy0_q <= cy0;
				rows_fwd_q <= 1'b1;
				cols_fwd_q <= 1'b1;
			end
			ST_CLIP2: begin
				dx0_q <= cx0;
				dy0_q <= cy0;
				nc_q <= cx1 - cx0 + 12'sd1;
				nr_q <= cy1 - cy0 + 12'sd1;
				rows_fwd_q <= cy0 <= sy0_q;
				cols_fwd_q <= cx0 <= sx0_q;
			end
			ST_ADDR: begin
				sa_q <= sa_n;
				da_q <= da_n;
			end
			ST_RD: rdat_q <= mem[sa_q];
			ST_WR: begin
				mem[da_q] <= op_q.is_copy ? rdat_q : op_q.value;
				if (12'(c_q) + 12'sd1 < nc_q) c_q <= c_q + 9'd1;
				else begin
					c_q <= '0;
					r_q <= r_q + 9'd1;
				end
			end
			ST_RES: begin
				read_cell <= op_q.is_read ? 16'(rdat_q) : 16'd0;
				nothing_done <= !acc_q;
			end
			default: ;
		endcase
	end

	a_clr_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !done) else $error("result during clear");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		op_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_done_after_res: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_RES) else $error("stray result");

endmodule

// ===== rtl/core/text_cell_blitter.sv =====
// per cell a fill steps through address and write, a copy through address, read and write
// a full-screen fill or copy of 4096 cells is paced by the one memory port
// throughput: one command at a time; busy stays high through the result strobe
// reset: config returns to 80x25, the store is cleared in a pass over all 4096 cells
// during which busy is high
// results cannot be stalled; done pulses one cycle with read_cell and nothing_done
module text_cell_blitter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [2:0]        req_type,
	input  logic [15:0]       cell_value,
	input  logic              whole_screen,
	input  logic signed [8:0] rect_x,
	input  logic signed [8:0] rect_y,
	input  logic [7:0]        rect_w,
	input  logic [7:0]        rect_h,
	input  logic signed [8:0] dest_x,
	input  logic signed [8:0] dest_y,
	input  logic signed [8:0] scroll_amount,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	output logic [15:0]       read_cell,
	output logic              nothing_done
);
	import tcb_pkg::*;

	logic [7:0] cols_q;
	logic [5:0] rows_q;
	logic [8:0] eff_cols, eff_rows;
	logic op_valid, op_ready, back_idle, fbusy, clearing;
	op_t op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd80;
			rows_q <= 6'd25;
		end else if (cfg_we) begin
			if (cfg_index == CFG_COLS) cols_q <= cfg_data;
			else rows_q <= cfg_data[5:0];
		end
	end

	assign eff_cols = 9'(cols_q) > 9'(MAX_COLS) ? 9'(MAX_COLS) : 9'(cols_q);
	assign eff_rows = 9'(rows_q) > 9'(MAX_ROWS) ? 9'(MAX_ROWS) : 9'(rows_q);
	assign clearing = !back_idle && !fbusy && !op_valid && !op_ready;
	assign busy = fbusy || clearing;

	tcb_front u_front (
		.clk, .arst_n, .start(start && !clearing), .busy(fbusy), .req_type, .cell_value,
		.whole_screen, .rect_x, .rect_y, .rect_w, .rect_h, .dest_x, .dest_y,
		.scroll_amount, .eff_cols, .eff_rows, .op_valid, .op, .op_ready,
		.back_idle
	);

	tcb_back u_back (
		.clk, .arst_n, .eff_cols, .eff_rows, .op_valid, .op, .op_ready,
		.idle(back_idle), .done, .read_cell, .nothing_done
	);

endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcb_pkg::*;

	localparam int WATCHDOG_CYCLES = 200000;
	localparam logic [2:0] REQ_SPARE6 = 3'd6;
	localparam logic [2:0] REQ_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0] op;
		int value;
		bit whole;
		int x, y, w, h, dx, dy, amt;
	} cmd_t;

	typedef struct {
		logic [15:0] cell_val;
		logic none;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [2:0] req_type = REQ_SET;
	logic [15:0] cell_value = '0;
	logic whole_screen = 1'b0;
	logic signed [8:0] rect_x = '0, rect_y = '0, dest_x = '0, dest_y = '0;
	logic signed [8:0] scroll_amount = '0;
	logic [7:0] rect_w = '0, rect_h = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_COLS;
	logic [7:0] cfg_data = '0;
	logic [15:0] read_cell;
	logic nothing_done;

	text_cell_blitter dut (.*);

	initial forever #6 clk = ~clk;

	// shadow of the screen store and the screen size
	logic [CELL_BITS-1:0] shadow_cells [STORE_CELLS];
	int unsigned width_reg = 80, height_reg = 25;
	outcome_t pending_outcomes[$];
	int mismatches = 0, transfers_in = 0, transfers_out = 0, reads_seen = 0;
	int idle_cycles = 0, sizes_tried = 0;

	function automatic int screen_w();
		return width_reg > MAX_COLS ? MAX_COLS : width_reg;
	endfunction

	function automatic int screen_h();
		return height_reg > MAX_ROWS ? MAX_ROWS : height_reg;
	endfunction

	function automatic int cell_addr(int x, int y);
		int unsigned a;
		a = x + y * screen_w();
		return a < STORE_CELLS ? a : 0;
	endfunction

	function automatic bit clip_empty(input int x, y, w, h, output int x0, y0, x1, y1);
		x0 = x < 0 ? 0 : x;
		y0 = y < 0 ? 0 : y;
		x1 = x + w - 1;
		y1 = y + h - 1;
		if (x1 >= screen_w()) x1 = screen_w() - 1;
		if (y1 >= screen_h()) y1 = screen_h() - 1;
		return x0 > x1 || y0 > y1;
	endfunction

	function automatic bit fill_rect(logic [15:0] v, int x, y, w, h);
		int x0, y0, x1, y1;
		if (clip_empty(x, y, w, h, x0, y0, x1, y1)) return 0;
		for (int j = y0; j <= y1; j++)
			for (int i = x0; i <= x1; i++)
				shadow_cells[cell_addr(i, j)] = v;
		return 1;
	endfunction

	function automatic bit copy_rect(int dx, dy, x, y, w, h);
		int sx0, sy0, sx1, sy1, dx0, dy0, dx1, dy1, nr, nc, ri, ci;
		if (clip_empty(x, y, w, h, sx0, sy0, sx1, sy1)) return 0;
		if (clip_empty(dx, dy, sx1 - sx0 + 1, sy1 - sy0 + 1, dx0, dy0, dx1, dy1)) return 0;
		nr = dy1 - dy0 + 1;
		nc = dx1 - dx0 + 1;
		for (int r = 0; r < nr; r++) begin
			ri = dy0 <= sy0 ? r : nr - 1 - r;
			for (int c = 0; c < nc; c++) begin
				ci = dx0 <= sx0 ? c : nc - 1 - c;
				shadow_cells[cell_addr(dx0 + ci, dy0 + ri)] =
					shadow_cells[cell_addr(sx0 + ci, sy0 + ri)];
			end
		end
		return 1;
	endfunction

	function automatic outcome_t apply_command(cmd_t c);
		outcome_t o;
		int x, y, w, h, a;
		bit did, cp, fl, on_screen;
		logic [15:0] v;
		x = c.x; y = c.y; w = c.w; h = c.h;
		v = c.value[15:0];
		did = 0;
		o.cell_val = '0;
		on_screen = x >= 0 && x < screen_w() && y >= 0 && y < screen_h();
		if (c.whole) begin
			x = 0; y = 0; w = screen_w(); h = screen_h();
		end
		a = c.amt < 0 ? -c.amt : c.amt;
		case (c.op)
			REQ_SET: begin
				if (on_screen) begin
					shadow_cells[cell_addr(x, y)] = v;
					did = 1;
				end
			end
			REQ_FILL: did = fill_rect(v, x, y, w, h);
			REQ_COPY: did = copy_rect(c.dx, c.dy, x, y, w, h);
			REQ_VSCROLL: begin
				if (c.amt > 0) begin
					cp = copy_rect(x, y + a, x, y, w, h - a);
					fl = fill_rect(v, x, y, w, a);
					did = cp || fl;
				end else if (c.amt < 0) begin
					cp = copy_rect(x, y, x, y + a, w, h - a);
					fl = fill_rect(v, x, y + h - a, w, a);
					did = cp || fl;
				end
			end
			REQ_HSCROLL: begin
				if (c.amt > 0) begin
					cp = copy_rect(x + a, y, x, y, w - a, h);
					fl = fill_rect(v, x, y, a, h);
					did = cp || fl;
				end else if (c.amt < 0) begin
					cp = copy_rect(x, y, x + a, y, w - a, h);
					fl = fill_rect(v, x + w - a, y, a, h);
					did = cp || fl;
				end
			end
			REQ_READ: begin
				if (on_screen) begin
					o.cell_val = shadow_cells[cell_addr(x, y)];
					did = 1;
				end
			end
			default: did = 0;
		endcase
		o.none = !did;
		return o;
	endfunction

	// result check, prediction at each accepted transfer, watchdog
	always @(posedge clk) begin
		cmd_t c;
		outcome_t exp_o;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (done) begin
				moved = 1'b1;
				transfers_out++;
				if (pending_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transfer");
				end else begin
					exp_o = pending_outcomes.pop_front();
					if (read_cell !== exp_o.cell_val || nothing_done !== exp_o.none) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: read_cell %h/%b expected %h/%b",
								transfers_out, read_cell, nothing_done, exp_o.cell_val,
								exp_o.none);
					end
				end
			end
			if (cfg_we) begin
				moved = 1'b1;
				if (cfg_index == CFG_COLS) width_reg = cfg_data;
				else height_reg = cfg_data[5:0];
			end
			if (start && !busy) begin
				moved = 1'b1;
				transfers_in++;
				c.op = req_type; c.value = cell_value; c.whole = whole_screen;
				c.x = rect_x; c.y = rect_y; c.w = rect_w; c.h = rect_h;
				c.dx = dest_x; c.dy = dest_y; c.amt = scroll_amount;
				if (c.op == REQ_READ && !c.whole) reads_seen++;
				pending_outcomes.push_back(apply_command(c));
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles > WATCHDOG_CYCLES) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_command(cmd_t c);
		repeat ($urandom_range(0, 7)) @(negedge clk);
		while (busy) @(negedge clk);
		req_type = c.op;
		cell_value = c.value[15:0];
		whole_screen = c.whole;
		rect_x = 9'(c.x); rect_y = 9'(c.y);
		rect_w = 8'(c.w); rect_h = 8'(c.h);
		dest_x = 9'(c.dx); dest_y = 9'(c.dy);
		scroll_amount = 9'(c.amt);
		start = 1'b1;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic issue(logic [2:0] op, int value, bit whole, int x, y,
		int w = 0, int h = 0, int dx = 0, int dy = 0, int amt = 0);
		cmd_t c;
		c.op = op; c.value = value; c.whole = whole;
		c.x = x; c.y = y; c.w = w; c.h = h; c.dx = dx; c.dy = dy; c.amt = amt;
		send_command(c);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_outcomes.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic set_screen(int cols, int rows);
		wait_drained();
		cfg_we = 1'b1; cfg_index = CFG_COLS; cfg_data = 8'(cols);
		@(negedge clk);
		cfg_index = CFG_ROWS; cfg_data = 8'(rows);
		@(negedge clk);
		cfg_we = 1'b0;
		sizes_tried++;
	endtask

	task automatic test_single_cells();
		issue(REQ_SET, 16'hffff, 0, 0, 0);
		issue(REQ_SET, 16'h0001, 0, 79, 24);
		issue(REQ_SET, 16'h1234, 0, -1, 0);
		issue(REQ_SET, 16'h1234, 0, 80, 24);
		issue(REQ_READ, 0, 0, 0, 0);
		issue(REQ_READ, 0, 0, 79, 24);
		issue(REQ_READ, 0, 0, -256, 255);
		issue(REQ_SPARE6, 16'hffff, 1, 0, 0);
		issue(REQ_SPARE7, 16'hffff, 0, 0, 0);
	endtask

	task automatic test_rect_ops();
		issue(REQ_FILL, 16'hbeef, 0, -3, -2, 10, 6);
		issue(REQ_COPY, 0, 0, 0, 0, 8, 5, 2, 1);
		issue(REQ_COPY, 0, 0, 2, 1, 8, 5, 0, 0);
		issue(REQ_COPY, 0, 0, 0, 0, 4, 4, 255, -256);
		issue(REQ_FILL, 16'h5a5a, 0, 70, 20, 255, 255);
		issue(REQ_VSCROLL, 16'h0700, 0, 0, 0, 12, 8, 0, 0, 2);
		issue(REQ_VSCROLL, 16'h0701, 0, 0, 0, 12, 8, 0, 0, -2);
		issue(REQ_VSCROLL, 16'h0702, 0, 0, 0, 12, 8, 0, 0, 0);
		issue(REQ_HSCROLL, 16'h0703, 0, 1, 1, 12, 8, 0, 0, 3);
		issue(REQ_HSCROLL, 16'h0704, 0, 1, 1, 12, 8, 0, 0, -3);
		issue(REQ_VSCROLL, 16'h0705, 0, 0, 0, 6, 3, 0, 0, -9);
		issue(REQ_HSCROLL, 16'h0706, 1, 0, 0, 0, 0, 0, 0, 255);
		issue(REQ_FILL, 16'h0000, 1, 5, 5);
		issue(REQ_READ, 0, 0, 3, 3);
		// sender holds off until the block has drained
		wait_drained();
		issue(REQ_READ, 0, 0, 79, 0);
	endtask

	task automatic test_screen_extremes();
		set_screen(0, 0);
		issue(REQ_FILL, 16'h1111, 1, 0, 0);
		issue(REQ_SET, 16'h2222, 0, 0, 0);
		issue(REQ_READ, 0, 0, 0, 0);
		set_screen(255, 63);
		issue(REQ_FILL, 16'h3333, 1, 0, 0);
		issue(REQ_SET, 16'h4444, 0, 127, 31);
		issue(REQ_COPY, 0, 0, 100, 20, 255, 255, 0, 0);
		issue(REQ_READ, 0, 0, 27, 11);
		issue(REQ_READ, 0, 0, 127, 31);
		set_screen(1, 1);
		issue(REQ_SET, 16'h5555, 0, 0, 0);
		issue(REQ_VSCROLL, 16'h6666, 1, 0, 0, 0, 0, 0, 0, -1);
		issue(REQ_READ, 0, 0, 0, 0);
		set_screen(128, 32);
		issue(REQ_READ, 0, 0, 127, 31);
	endtask

	function automatic int pick_coord(int span);
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, span + 4) - 2;
		return $urandom_range(0, 511) - 256;
	endfunction

	function automatic int pick_size(int span);
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, span + 2);
		return $urandom_range(0, 255);
	endfunction

	task automatic test_random_commands(int count);
		cmd_t c;
		int cw, ch;
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0) begin
				if (n % 60 == 40) set_screen($urandom_range(100, 255), $urandom_range(28, 63));
				else set_screen($urandom_range(1, 24), $urandom_range(1, 10));
			end
			cw = screen_w(); ch = screen_h();
			c.op = $urandom_range(0, 19) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5);
			c.value = $urandom_range(0, 16'hffff);
			c.whole = $urandom_range(0, 4) == 0 && (cw < 64 || $urandom_range(0, 2) == 0);
			c.x = pick_coord(cw); c.y = pick_coord(ch);
			c.w = pick_size(cw < 40 ? cw : 12); c.h = pick_size(ch < 40 ? ch : 8);
			c.dx = pick_coord(cw); c.dy = pick_coord(ch);
			if ($urandom_range(0, 3) != 0) c.amt = $urandom_range(0, 10) - 5;
			else c.amt = $urandom_range(0, 510) - 255;
			if (cw >= 64 && !c.whole) begin
				c.w = c.w > 16 ? 16 : c.w;
				c.h = c.h > 16 ? 16 : c.h;
			end
			send_command(c);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_single_cells();
		test_rect_ops();
		test_screen_extremes();
		test_random_commands(100);
		wait_drained();
		repeat (50) @(negedge clk);
		$display("%0d commands sent, %0d results checked, %0d single-cell reads",
			transfers_in, transfers_out, reads_seen);
		$display("%0d screen sizes tried, including empty and oversized", sizes_tried);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
